// ===== hw/rtl/fsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants for the frame and swap slot allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int FRAMES_DEF   = 64;
  localparam int SLOTS_DEF    = 64;
  localparam int QDEPTH_DEF   = 2;

  localparam int PW_W         = 13;
  localparam int REQ_W        = 18;
  localparam int TGT_W        = 6;
  localparam int GI_W         = 6;
  localparam int PAGES_W      = 7;
  localparam int RESULT_LIMIT = 64;
  localparam int DIV_STEPS    = REQ_W;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  localparam logic [PW_W-1:0] PAGE_WORDS_RST = PW_W'(16);

  typedef enum logic [1:0] {
    OP_ALLOC_FRAMES = 2'd0,
    OP_FREE_FRAME   = 2'd1,
    OP_ALLOC_SLOT   = 2'd2,
    OP_FREE_SLOT    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_GRANT  = 2'd0,
    ST_REFUSE = 2'd1,
    ST_ACK    = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic               big;
    logic [PAGES_W-1:0] pages;
    logic [TGT_W-1:0]   target;
  } cmd_t;

endpackage

// ===== hw/rtl/frame_and_swap_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_and_swap_slot_allocator
// Page frame bitmap allocator with clock replacement for swap slots.
// ----------------------------------------------------------------------------
// Frees: one request a cycle while the queue is not full; the result is registered.
// Frame allocation: 18 divider steps (one quotient bit each), one queue push;
//   no new request is taken meanwhile. A refusal or zero-size answer is one result;
//   grants examine one frame a cycle, up to FRAMES, a free frame waiting on the output.
// Slot allocation: up to SLOTS scan steps plus up to SLOTS+1 sweep steps.
// Synchronous active-low reset: all frames and slots free, hand at zero, 16-word pages.
module frame_and_swap_slot_allocator #(
  parameter int FRAMES = fsa_pkg::FRAMES_DEF,
  parameter int SLOTS  = fsa_pkg::SLOTS_DEF,
  parameter int QDEPTH = fsa_pkg::QDEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fsa_pkg::PW_W-1:0]  cfg_data,    // page_words
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [1:0]                in_tuser,    // kind
  input  logic [23:0]               in_tdata,    // request_words, target_index
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [2:0]                out_tuser,   // status, victim
  output logic [7:0]                out_tdata,   // granted_index, zero pad
  output logic                      out_tlast    // last
);
  import fsa_pkg::*;

  logic [PW_W-1:0] page_words_r;
  logic            q_push, q_full, q_pop, q_empty;
  cmd_t            push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_words_r <= PAGE_WORDS_RST;
    end else if (cfg_valid) begin
      page_words_r <= cfg_data;
    end
  end

  fsa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .page_words (page_words_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  fsa_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  fsa_back #(
    .FRAMES (FRAMES),
    .SLOTS  (SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/fsa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_front
// Accepts requests, turns frame sizes into page counts, queues commands.
// ----------------------------------------------------------------------------
module fsa_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [fsa_pkg::PW_W-1:0]   page_words,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [1:0]                 in_tuser,
  input  logic [23:0]                in_tdata,
  input  logic                       q_full,
  output logic                       q_push,
  output fsa_pkg::cmd_t              q_cmd
);
  import fsa_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                 state_r, state_nxt;
  logic [REQ_W-1:0]        dvd_r, dvd_nxt;
  logic [PW_W-1:0]         rem_r, rem_nxt;
  logic [PW_W-1:0]         pw_r, pw_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [TGT_W-1:0]        tgt_r, tgt_nxt;
  logic [PW_W:0]           trial;
  logic                    fit;
  logic [REQ_W:0]          pages_full;
  logic                    big;
  logic                    accept;
  logic [REQ_W-1:0]        req;
  logic [TGT_W-1:0]        tgt;

  assign req        = in_tdata[REQ_W-1:0];
  assign tgt        = in_tdata[REQ_W +: TGT_W];
  assign in_tready  = (state_r == F_IDLE) && !q_full;
  assign accept     = in_tvalid && in_tready;

  assign trial      = {rem_r, dvd_r[REQ_W-1]};
  assign fit        = trial >= {1'b0, pw_r};
  assign pages_full = (REQ_W+1)'(dvd_r) + (REQ_W+1)'(rem_r != '0);
  assign big        = 32'(pages_full) > RESULT_LIMIT;

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    pw_nxt    = pw_r;
    step_nxt  = step_r;
    tgt_nxt   = tgt_r;
    q_push    = 1'b0;
    q_cmd     = '{op: op_t'(in_tuser), big: 1'b0, pages: '0, target: tgt};
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (op_t'(in_tuser) == OP_ALLOC_FRAMES) begin
            dvd_nxt   = req;
            rem_nxt   = '0;
            pw_nxt    = (page_words == '0) ? PW_W'(1) : page_words;
            step_nxt  = '0;
            tgt_nxt   = tgt;
            state_nxt = F_DIV;
          end else begin
            q_push = 1'b1;
          end
        end
      end
      F_DIV: begin
        rem_nxt  = fit ? PW_W'(trial - {1'b0, pw_r}) : trial[PW_W-1:0];
        dvd_nxt  = {dvd_r[REQ_W-2:0], fit};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        q_cmd = '{op: OP_ALLOC_FRAMES, big: big,
                  pages: big ? '0 : PAGES_W'(pages_full), target: tgt_r};
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    pw_r   <= pw_nxt;
    step_r <= step_nxt;
    tgt_r  <= tgt_nxt;
  end

endmodule

// ===== hw/rtl/fsa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module fsa_queue #(
  parameter int DEPTH = fsa_pkg::QDEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fsa_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output fsa_pkg::cmd_t  pop_cmd,
  output logic           empty
);
  import fsa_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/fsa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_back
// Executes queued commands on the frame and slot tables, drives results.
// ----------------------------------------------------------------------------
module fsa_back #(
  parameter int FRAMES = fsa_pkg::FRAMES_DEF,
  parameter int SLOTS  = fsa_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  fsa_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [2:0]     out_tuser,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);
  import fsa_pkg::*;

  localparam int FIW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FCW = $clog2(FRAMES + 1);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_FSCAN = 4'b0010,
    B_SSCAN = 4'b0100,
    B_SWEEP = 4'b1000
  } bstate_t;

  bstate_t              state_r, state_nxt;
  logic [FRAMES-1:0]    used_r, used_nxt;
  logic [SLOTS-1:0]     occ_r, occ_nxt;
  logic [SLOTS-1:0]     ref_r, ref_nxt;
  logic [FCW-1:0]       free_r, free_nxt;
  logic [FIW-1:0]       fidx_r, fidx_nxt;
  logic [SIW-1:0]       sidx_r, sidx_nxt;
  logic [SIW-1:0]       hand_r, hand_nxt;
  logic [PAGES_W-1:0]   pages_r, pages_nxt;
  logic [PAGES_W-1:0]   n_r, n_nxt;

  logic                 ov_r;
  status_t              ost_r;
  logic [GI_W-1:0]      oidx_r;
  logic                 ovic_r, olast_r;

  logic                 out_ok;
  logic                 o_load;
  status_t              o_st;
  logic [GI_W-1:0]      o_idx;
  logic                 o_vic, o_last;
  logic                 fr_last;

  assign out_ok     = !ov_r || out_tready;
  assign out_tvalid = ov_r;
  assign out_tuser  = {ovic_r, ost_r};
  assign out_tdata  = {{(8 - GI_W){1'b0}}, oidx_r};
  assign out_tlast  = olast_r;
  assign fr_last    = PAGES_W'(n_r + 1'b1) == pages_r;

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    occ_nxt   = occ_r;
    ref_nxt   = ref_r;
    free_nxt  = free_r;
    fidx_nxt  = fidx_r;
    sidx_nxt  = sidx_r;
    hand_nxt  = hand_r;
    pages_nxt = pages_r;
    n_nxt     = n_r;
    q_pop     = 1'b0;
    o_load    = 1'b0;
    o_st      = ST_ACK;
    o_idx     = '0;
    o_vic     = 1'b0;
    o_last    = 1'b1;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty && out_ok) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            OP_ALLOC_FRAMES: begin
              if (q_cmd.pages == '0 && !q_cmd.big) begin
                o_load = 1'b1;
              end else if (q_cmd.big || 32'(q_cmd.pages) > 32'(free_r)) begin
                o_load = 1'b1;
                o_st   = ST_REFUSE;
              end else begin
                pages_nxt = q_cmd.pages;
                n_nxt     = '0;
                fidx_nxt  = '0;
                state_nxt = B_FSCAN;
              end
            end
            OP_FREE_FRAME: begin
              if (32'(q_cmd.target) < FRAMES && used_r[FIW'(q_cmd.target)]) begin
                used_nxt[FIW'(q_cmd.target)] = 1'b0;
                free_nxt = free_r + 1'b1;
              end
              o_load = 1'b1;
            end
            OP_ALLOC_SLOT: begin
              sidx_nxt  = '0;
              state_nxt = B_SSCAN;
            end
            OP_FREE_SLOT: begin
              if (32'(q_cmd.target) < SLOTS) begin
                occ_nxt[SIW'(q_cmd.target)] = 1'b0;
              end
              o_load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      B_FSCAN: begin
        if (used_r[fidx_r]) begin
          fidx_nxt = FIW'(fidx_r + 1'b1);
        end else if (out_ok) begin
          used_nxt[fidx_r] = 1'b1;
          free_nxt = free_r - 1'b1;
          o_load   = 1'b1;
          o_st     = ST_GRANT;
          o_idx    = GI_W'(fidx_r);
          o_last   = fr_last;
          n_nxt    = PAGES_W'(n_r + 1'b1);
          fidx_nxt = FIW'(fidx_r + 1'b1);
          if (fr_last) begin
            state_nxt = B_IDLE;
          end
        end
      end
      B_SSCAN: begin
        if (!occ_r[sidx_r]) begin
          if (out_ok) begin
            occ_nxt[sidx_r] = 1'b1;
            ref_nxt[sidx_r] = 1'b1;
            o_load    = 1'b1;
            o_st      = ST_GRANT;
            o_idx     = GI_W'(sidx_r);
            state_nxt = B_IDLE;
          end
        end else if (sidx_r == SIW'(SLOTS - 1)) begin
          state_nxt = B_SWEEP;
        end else begin
          sidx_nxt = SIW'(sidx_r + 1'b1);
        end
      end
      B_SWEEP: begin
        if (ref_r[hand_r]) begin
          ref_nxt[hand_r] = 1'b0;
          hand_nxt = (hand_r == SIW'(SLOTS - 1)) ? '0 : SIW'(hand_r + 1'b1);
        end else if (out_ok) begin
          ref_nxt[hand_r] = 1'b1;
          o_load    = 1'b1;
          o_st      = ST_GRANT;
          o_idx     = GI_W'(hand_r);
          o_vic     = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      used_r  <= '0;
      occ_r   <= '0;
      ref_r   <= '0;
      free_r  <= FCW'(FRAMES);
      hand_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      occ_r   <= occ_nxt;
      ref_r   <= ref_nxt;
      free_r  <= free_nxt;
      hand_r  <= hand_nxt;
      if (o_load) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
    fidx_r  <= fidx_nxt;
    sidx_r  <= sidx_nxt;
    pages_r <= pages_nxt;
    n_r     <= n_nxt;
    if (o_load) begin
      ost_r   <= o_st;
      oidx_r  <= o_idx;
      ovic_r  <= o_vic;
      olast_r <= o_last;
    end
  end

endmodule

// ===== test/frame_and_swap_slot_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_and_swap_slot_allocator_test
// Self-checking bench for the frame and swap slot allocator. A short table of
// directed requests runs after reset. Random request mixes follow under several
// page sizes. A behavioral allocator predicts the results of untyped requests, and a monitor
// compares each result field by field in order.
// ----------------------------------------------------------------------------
module frame_and_swap_slot_allocator_test;
  import fsa_pkg::*;

  localparam int FRAMES = FRAMES_DEF;
  localparam int SLOTS  = SLOTS_DEF;
  localparam int MAX_WORDS = (1 << REQ_W) - 1;

  typedef struct {
    status_t        st;
    logic [GI_W-1:0] gi;
    logic           vic;
    logic           lst;
  } grant_t;

  typedef struct packed {
    op_t              kind;
    logic [REQ_W-1:0] words;
    logic [TGT_W-1:0] index;
    logic             typed;
    status_t          st;
    logic [GI_W-1:0]  gi;
  } row_t;

  // typed rows: single result, victim 0, last 1
  localparam row_t DIRECTED [21] = '{
    '{OP_ALLOC_FRAMES, 18'd0,      6'd0,  1'b1, ST_ACK,    6'd0},
    '{OP_ALLOC_FRAMES, 18'd1,      6'd0,  1'b1, ST_GRANT,  6'd0},
    '{OP_ALLOC_FRAMES, 18'd16,     6'd0,  1'b1, ST_GRANT,  6'd1},
    '{OP_ALLOC_FRAMES, 18'd17,     6'd0,  1'b0, ST_GRANT,  6'd0},
    '{OP_ALLOC_FRAMES, 18'h3FFFF,  6'd63, 1'b1, ST_REFUSE, 6'd0},
    '{OP_ALLOC_FRAMES, 18'd1024,   6'd0,  1'b1, ST_REFUSE, 6'd0},
    '{OP_FREE_FRAME,   18'd0,      6'd0,  1'b1, ST_ACK,    6'd0},
    '{OP_FREE_FRAME,   18'd0,      6'd0,  1'b1, ST_ACK,    6'd0},
    '{OP_ALLOC_FRAMES, 18'd976,    6'd0,  1'b0, ST_GRANT,  6'd0},
    '{OP_ALLOC_FRAMES, 18'd1,      6'd0,  1'b1, ST_REFUSE, 6'd0},
    '{OP_FREE_FRAME,   18'd0,      6'd63, 1'b1, ST_ACK,    6'd0},
    '{OP_ALLOC_FRAMES, 18'd16,     6'd0,  1'b1, ST_GRANT,  6'd63},
    '{OP_FREE_FRAME,   18'h3FFFF,  6'd32, 1'b1, ST_ACK,    6'd0},
    '{OP_ALLOC_SLOT,   18'h3FFFF,  6'd63, 1'b1, ST_GRANT,  6'd0},
    '{OP_ALLOC_SLOT,   18'd0,      6'd0,  1'b1, ST_GRANT,  6'd1},
    '{OP_FREE_SLOT,    18'd0,      6'd0,  1'b1, ST_ACK,    6'd0},
    '{OP_FREE_SLOT,    18'h3FFFF,  6'd63, 1'b1, ST_ACK,    6'd0},
    '{OP_ALLOC_SLOT,   18'd0,      6'd0,  1'b1, ST_GRANT,  6'd0},
    '{OP_ALLOC_SLOT,   18'd0,      6'd0,  1'b1, ST_GRANT,  6'd2},
    '{OP_FREE_FRAME,   18'd0,      6'd1,  1'b1, ST_ACK,    6'd0},
    '{OP_ALLOC_FRAMES, 18'd32,     6'd0,  1'b0, ST_GRANT,  6'd0}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [PW_W-1:0]  cfg_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [1:0]       in_tuser = '0;   // kind
  logic [23:0]      in_tdata = '0;   // request_words, target_index
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [2:0]       out_tuser;       // status, victim
  logic [7:0]       out_tdata;       // granted_index, zero pad
  logic             out_tlast;       // last

  frame_and_swap_slot_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator state as predicted
  bit              frame_used [FRAMES];
  bit              slot_occupied [SLOTS];
  bit              slot_referenced [SLOTS];
  int              clock_hand = 0;
  logic [PW_W-1:0] page_words = PAGE_WORDS_RST;

  grant_t pending_grants [$];
  int     errors = 0;
  int     burst_left = 0;
  bit     in_busy = 1'b0;

  function automatic void expect_grant(status_t st, int gi, logic vic, logic lst);
    grant_t g;
    g.st  = st;
    g.gi  = GI_W'(gi);
    g.vic = vic;
    g.lst = lst;
    pending_grants.insert(pending_grants.size(), g);
  endfunction

  function automatic void predict_grants(op_t k, logic [REQ_W-1:0] words,
                                         logic [TGT_W-1:0] idx);
    int eff;
    int pages;
    int nfree;
    int n;
    case (k)
      OP_ALLOC_FRAMES: begin
        eff = (page_words == 0) ? 1 : int'(page_words);
        pages = (int'(words) + eff - 1) / eff;
        nfree = 0;
        foreach (frame_used[i]) if (!frame_used[i]) nfree++;
        if (pages == 0) begin
          expect_grant(ST_ACK, 0, 1'b0, 1'b1);
        end else if (pages > nfree || pages > RESULT_LIMIT) begin
          expect_grant(ST_REFUSE, 0, 1'b0, 1'b1);
        end else begin
          n = 0;
          for (int i = 0; i < FRAMES && n < pages; i++) begin
            if (!frame_used[i]) begin
              frame_used[i] = 1'b1;
              n++;
              expect_grant(ST_GRANT, i, 1'b0, n == pages);
            end
          end
        end
      end
      OP_FREE_FRAME: begin
        if (int'(idx) < FRAMES) frame_used[idx] = 1'b0;
        expect_grant(ST_ACK, 0, 1'b0, 1'b1);
      end
      OP_ALLOC_SLOT: begin
        n = -1;
        for (int i = 0; i < SLOTS && n < 0; i++) if (!slot_occupied[i]) n = i;
        if (n >= 0) begin
          slot_occupied[n] = 1'b1;
          slot_referenced[n] = 1'b1;
          expect_grant(ST_GRANT, n, 1'b0, 1'b1);
        end else begin
          // clock sweep; hand stays on the victim
          while (slot_referenced[clock_hand]) begin
            slot_referenced[clock_hand] = 1'b0;
            clock_hand = (clock_hand + 1) % SLOTS;
          end
          slot_referenced[clock_hand] = 1'b1;
          expect_grant(ST_GRANT, clock_hand, 1'b1, 1'b1);
        end
      end
      default: begin
        if (int'(idx) < SLOTS) slot_occupied[idx] = 1'b0;
        expect_grant(ST_ACK, 0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_request(op_t k, logic [REQ_W-1:0] words, logic [TGT_W-1:0] idx,
                              logic typed, status_t st, logic [GI_W-1:0] gi);
    int n0;
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {idx, words};
    in_busy = 1'b1;
    do @(posedge clk); while (!in_tready);
    n0 = pending_grants.size();
    predict_grants(k, words, idx);
    if (typed) begin
      while (pending_grants.size() > n0) void'(pending_grants.pop_back());
      expect_grant(st, int'(gi), 1'b0, 1'b1);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      in_busy = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // hold off requests until every predicted result has come back
  task automatic drain();
    if (in_busy) begin
      in_tvalid <= 1'b0;
      in_busy = 1'b0;
    end
    burst_left = 0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reconfigure(logic [PW_W-1:0] pw);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= pw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    page_words = pw;
  endtask

  task automatic random_requests(int count);
    int pick;
    int span;
    op_t k;
    logic [REQ_W-1:0] words;
    logic [TGT_W-1:0] idx;
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) drain();
      pick  = $urandom_range(0, 99);
      words = REQ_W'($urandom);
      idx   = TGT_W'($urandom);
      if (pick < 35) begin
        k = OP_ALLOC_FRAMES;
        span = ((page_words == 0) ? 1 : int'(page_words)) * 6;
        if (span > MAX_WORDS) span = MAX_WORDS;
        case ($urandom_range(0, 9))
          0:       words = '0;
          1:       words = REQ_W'($urandom);
          default: words = REQ_W'($urandom_range(1, span));
        endcase
      end else if (pick < 65) begin
        k = OP_FREE_FRAME;
      end else if (pick < 90) begin
        k = OP_ALLOC_SLOT;
      end else begin
        k = OP_FREE_SLOT;
      end
      send_request(k, words, idx, 1'b0, ST_GRANT, '0);
    end
  endtask

  // result side stalls in modes that change each time the 7-bit counter wraps
  logic [6:0] rx_count = '0;
  logic [1:0] rx_mode = '0;

  always @(posedge clk) begin
    rx_count <= rx_count + 7'd1;
    if (rx_count == '0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= rx_count[2];
    endcase
  end

  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected result, status", int'(out_tuser[1:0]), -1);
      end else begin
        g = pending_grants.pop_front();
        if (out_tuser[1:0] != g.st) report_mismatch("status", out_tuser[1:0], g.st);
        if (out_tdata[5:0] != g.gi) report_mismatch("granted_index", out_tdata[5:0], g.gi);
        if (out_tdata[7:6] != 2'b00) report_mismatch("tdata pad", out_tdata[7:6], 0);
        if (out_tuser[2] != g.vic) report_mismatch("victim", out_tuser[2], g.vic);
        if (out_tlast != g.lst) report_mismatch("last", out_tlast, g.lst);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_request(DIRECTED[i].kind, DIRECTED[i].words, DIRECTED[i].index,
                   DIRECTED[i].typed, DIRECTED[i].st, DIRECTED[i].gi);

    // one-word pages; fill every swap slot so the clock sweep takes over
    reconfigure(PW_W'(1));
    repeat (70) send_request(OP_ALLOC_SLOT, REQ_W'($urandom), TGT_W'($urandom),
                             1'b0, ST_GRANT, '0);
    random_requests(30);

    // 4096-word pages; free every frame, then ask for all 64 at once
    reconfigure(PW_W'(4096));
    for (int i = 0; i < FRAMES; i++)
      send_request(OP_FREE_FRAME, REQ_W'($urandom), TGT_W'(i), 1'b0, ST_GRANT, '0);
    send_request(OP_ALLOC_FRAMES, REQ_W'(MAX_WORDS), '0, 1'b0, ST_GRANT, '0);
    random_requests(30);

    reconfigure('0);
    random_requests(20);

    reconfigure('1);
    random_requests(20);

    reconfigure(PW_W'($urandom_range(2, 300)));
    random_requests(40);

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
